// File: sv/slpd_pkg.sv
// ----------------------------------------------------------------------------
// slpd_pkg
// Shared types and constants of the sprite line pixel decoder.
// ----------------------------------------------------------------------------
package slpd_pkg;

  // pixel format codes (code 3 behaves as the 16 pixel format)
  localparam logic [1:0] FMT_4PIX  = 2'd0;
  localparam logic [1:0] FMT_8PIX  = 2'd1;
  localparam logic [1:0] FMT_16PIX = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_FORMAT = 2'd0;
  localparam logic [1:0] REG_TOP    = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam int          NUM_PIX   = 16;
  localparam int          IDX_W     = 4;
  localparam logic [3:0]  PIX_CLEAR = 4'h0;
  localparam logic [3:0]  PIX_MARK  = 4'hF;
  localparam logic [11:0] COL_MAX   = 12'hFFF;
  localparam logic [15:0] LINE_MAX  = 16'hFFFF;

  // depth of the queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = 2;

  // one word's worth of work for the back end
  typedef struct packed {
    logic [63:0] word;   // pixels left-aligned, pixel 0 in bits 63:60
    logic [15:0] mask;   // bit i set: pixel i is emitted
    logic [11:0] col;    // column of pixel 0
    logic [15:0] sy;     // window-relative line
  } job_t;

endpackage

// File: sv/slpd_front.sv
// ----------------------------------------------------------------------------
// slpd_front
// Accepts pattern words, keeps the column and line counters and the
// configuration, and turns each visible word into an emit mask job.
// ----------------------------------------------------------------------------
module slpd_front #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,
  input  logic               in_tuser,
  input  logic               q_full,
  output logic               q_push,
  output slpd_pkg::job_t     q_job
);
  import slpd_pkg::*;

  localparam logic [12:0] SW = 13'(SCREEN_WIDTH);

  logic [1:0]  fmt_r;
  logic [15:0] top_r, height_r;
  logic [11:0] col_r, col_nxt;
  logic [15:0] line_r, line_nxt;

  logic        in_acc;
  logic [11:0] col_eff;
  logic [15:0] line_eff;
  logic [63:0] norm;
  logic [4:0]  npix;
  logic        blank, endmark, skip, in_win;
  logic [16:0] win_end;
  logic [15:0] mask;
  logic [12:0] col_sum;

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  // counters as seen by this word
  assign col_eff  = in_tuser ? 12'd0 : col_r;
  assign line_eff = in_tuser ? 16'd0 : line_r;

  // format decode: left-align pixels, blank and end marker detection
  always_comb begin
    case (fmt_r)
      FMT_4PIX: begin
        norm    = {in_tdata[15:0], 48'd0};
        npix    = 5'd4;
        blank   = (in_tdata[15:0] == 16'd0) || (in_tdata[3:0] == PIX_MARK);
        endmark = in_tdata[3:0] == PIX_MARK;
      end
      FMT_8PIX: begin
        norm    = {in_tdata[31:0], 32'd0};
        npix    = 5'd8;
        blank   = in_tdata[31:0] == {24'd0, PIX_MARK, PIX_CLEAR};
        endmark = in_tdata[7:4] == PIX_MARK;
      end
      default: begin
        norm    = in_tdata;
        npix    = 5'd16;
        blank   = (in_tdata[63:32] == 32'd0) && (in_tdata[31:0] == {28'd0, PIX_MARK});
        endmark = in_tdata[3:0] == PIX_MARK;
      end
    endcase
  end

  assign skip    = (col_eff == 12'd0) && blank;
  assign win_end = {1'b0, top_r} + {1'b0, height_r};
  assign in_win  = (line_eff >= top_r) && ({1'b0, line_eff} < win_end);

  // per-pixel emit decision
  always_comb begin
    logic [3:0]  pix;
    logic [12:0] x;
    for (int i = 0; i < NUM_PIX; i++) begin
      pix     = norm[63 - 4*i -: 4];
      x       = {1'b0, col_eff} + 13'(i);
      mask[i] = (5'(i) < npix) && (x < SW) && (pix != PIX_CLEAR) && (pix != PIX_MARK);
    end
  end

  assign q_push   = in_acc && !skip && in_win && (mask != 16'd0);
  assign q_job    = '{word: norm, mask: mask, col: col_eff, sy: line_eff - top_r};

  // counter update
  assign col_sum = {1'b0, col_eff} + {8'd0, npix};
  always_comb begin
    col_nxt  = col_r;
    line_nxt = line_r;
    if (in_acc) begin
      col_nxt  = col_eff;
      line_nxt = line_eff;
      if (!skip) begin
        col_nxt = col_sum[12] ? COL_MAX : col_sum[11:0];
        if (endmark) begin
          col_nxt = 12'd0;
          if (line_eff != LINE_MAX) line_nxt = line_eff + 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      line_r   <= '0;
      fmt_r    <= FMT_4PIX;
      top_r    <= '0;
      height_r <= '0;
    end else begin
      col_r  <= col_nxt;
      line_r <= line_nxt;
      // configuration writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_FORMAT: fmt_r    <= cfg_wdata[1:0];
          REG_TOP:    top_r    <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

endmodule

// File: sv/slpd_queue.sv
// ----------------------------------------------------------------------------
// slpd_queue
// Short job queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module slpd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  slpd_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           nempty,
  output slpd_pkg::job_t head_job
);
  import slpd_pkg::*;

  job_t               mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_r, rd_r;
  logic [Q_PTR_W:0]   cnt_r;
  logic               do_push, do_pop;

  assign full     = cnt_r == (Q_PTR_W+1)'(Q_DEPTH);
  assign nempty   = cnt_r != '0;
  assign head_job = mem_r[rd_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nempty;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop)  rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (Q_PTR_W+1)'(do_push) - (Q_PTR_W+1)'(do_pop);
    end
  end

endmodule

// File: sv/slpd_back.sv
// ----------------------------------------------------------------------------
// slpd_back
// Walks the emit mask of each job, one pixel a cycle while the output is not
// stalled, into the output register.
// ----------------------------------------------------------------------------
module slpd_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_nempty,
  input  slpd_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [31:0]    out_tdata,
  output logic           out_tlast
);
  import slpd_pkg::*;

  job_t             cur_r, cur_nxt;
  logic             cur_vld_r, cur_vld_nxt;
  logic             ovld_r, ovld_nxt;
  logic [8:0]       ox_r, ox_nxt;
  logic [15:0]      oy_r, oy_nxt;
  logic [3:0]       opix_r, opix_nxt;
  logic             olast_r, olast_nxt;

  logic             out_adv, emit;
  logic [IDX_W-1:0] idx;
  logic [15:0]      rest;
  logic [12:0]      x_sum;

  assign out_adv = !ovld_r || out_tready;
  assign emit    = cur_vld_r && out_adv;

  // lowest pending pixel
  always_comb begin
    idx = '0;
    for (int i = NUM_PIX - 1; i >= 0; i--) begin
      if (cur_r.mask[i]) idx = IDX_W'(i);
    end
  end

  assign rest  = cur_r.mask & ~(16'd1 << idx);
  assign x_sum = {1'b0, cur_r.col} + {9'd0, idx};

  // load a new job when idle or when the current one finishes
  assign q_pop = q_nempty && (!cur_vld_r || (emit && (rest == 16'd0)));

  always_comb begin
    cur_nxt     = cur_r;
    cur_vld_nxt = cur_vld_r;
    ovld_nxt    = ovld_r && !out_tready;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    opix_nxt    = opix_r;
    olast_nxt   = olast_r;
    if (emit) begin
      ovld_nxt     = 1'b1;
      ox_nxt       = x_sum[8:0];
      oy_nxt       = cur_r.sy;
      opix_nxt     = cur_r.word[63 - 4*idx -: 4];
      olast_nxt    = rest == 16'd0;
      cur_nxt.mask = rest;
      if (rest == 16'd0) cur_vld_nxt = 1'b0;
    end
    if (q_pop) begin
      cur_nxt     = q_job;
      cur_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    ox_r    <= ox_nxt;
    oy_r    <= oy_nxt;
    opix_r  <= opix_nxt;
    olast_r <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      ovld_r    <= 1'b0;
    end else begin
      cur_vld_r <= cur_vld_nxt;
      ovld_r    <= ovld_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'd0, opix_r, oy_r, ox_r};
  assign out_tlast  = olast_r;

endmodule

// File: sv/sprite_line_pixel_decoder.sv
// ----------------------------------------------------------------------------
// sprite_line_pixel_decoder
// Decodes packed 4-bit sprite pixels into opaque on-screen pixel results.
// ----------------------------------------------------------------------------
// Path: a word goes from the job queue via the job register to the output register.
// Throughput: one word per cycle while the four-entry job queue has room; a
//   word with n opaque on-screen pixels yields n results, one per cycle while
//   the output is not stalled, and a word with none never reaches the back end.
// Reset: synchronous, active low; clears counters, registers, queue, output.
// ----------------------------------------------------------------------------
module sprite_line_pixel_decoder #(
  parameter int SCREEN_WIDTH = 320
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] pattern_word
  input  logic        in_tuser,   // [0] first_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [8:0] pixel_x, [24:9] pixel_y, [28:25] pixel_value
  output logic        out_tlast
);
  import slpd_pkg::*;

  job_t push_job, head_job;
  logic push, full, pop, nempty;

  slpd_front #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  slpd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .nempty   (nempty),
    .head_job (head_job)
  );

  slpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nempty   (nempty),
    .q_job      (head_job),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
